// ----- rtl/gstw_pkg.sv -----
// Package for the grid segment tile walk: transaction payload types, control
// and status structs, controller states and fixed constants.
// Depends on nothing; every other file of the block uses it.
package gstw_pkg;

   localparam int unsigned COORD_IN_W = 16;
   localparam int unsigned TILE_W     = 5;
   localparam int unsigned MAX_TILES  = 63;
   localparam int unsigned CNT_W      = $clog2(MAX_TILES + 1);

   typedef struct packed {
      logic [COORD_IN_W-1:0] start_x;
      logic [COORD_IN_W-1:0] start_y;
      logic [COORD_IN_W-1:0] end_x;
      logic [COORD_IN_W-1:0] end_y;
   } gstw_req_type;

   typedef struct packed {
      logic [TILE_W-1:0] tile_x;
      logic [TILE_W-1:0] tile_y;
      logic              last_tile;
   } gstw_rsp_type;

   typedef struct packed {
      logic load;
      logic mult;
      logic step;
   } gstw_cmd_type;

   typedef struct packed {
      logic same_tile;
      logic reach_goal;
   } gstw_status_type;

   typedef enum logic [1:0] {
      GSTW_IDLE,
      GSTW_MULT,
      GSTW_WALK
   } gstw_state_type;

endpackage

// ----- rtl/gstw_datapath.sv -----
// Datapath of the grid segment tile walk: tile registers, boundary crossing
// accumulators and the registered result.
// Depends on gstw_pkg; driven by gstw_controller commands.
module gstw_datapath #(
   parameter int unsigned GRID_BITS = 5,
   parameter int unsigned FRAC_BITS = 11
) (
   input  logic                     clock,
   input  logic                     reset,
   input  gstw_pkg::gstw_req_type   req_data,
   input  gstw_pkg::gstw_cmd_type   cmd,
   output gstw_pkg::gstw_status_type status,
   output logic                     rsp_strobe,
   output gstw_pkg::gstw_rsp_type   rsp_data
);

   localparam int unsigned COORD_W = GRID_BITS + FRAC_BITS;
   localparam int unsigned DIST_W  = FRAC_BITS + 1;
   localparam int unsigned MUL_W   = DIST_W + COORD_W;
   localparam int unsigned PROD_W  = 2 * COORD_W + 1;
   localparam logic [DIST_W-1:0] TILE_SIZE = DIST_W'(1) << FRAC_BITS;

   logic [31:0]          x0_wide, y0_wide, x1_wide, y1_wide;
   logic [COORD_W-1:0]   x0, y0, x1, y1;
   logic [GRID_BITS-1:0] col0, row0, col1, row1;
   logic                 x_up, x_down, y_up, y_down;

   logic [GRID_BITS-1:0] cur_col_ff, cur_col_in, cur_row_ff, cur_row_in;
   logic [GRID_BITS-1:0] goal_col_ff, goal_col_in, goal_row_ff, goal_row_in;
   logic [DIST_W-1:0]    dist_x_ff, dist_x_in, dist_y_ff, dist_y_in;
   logic [COORD_W-1:0]   adx_ff, adx_in, ady_ff, ady_in;
   logic                 x_down_ff, x_down_in, y_down_ff, y_down_in;
   logic [PROD_W-1:0]    tx_ff, tx_in, ty_ff, ty_in;
   logic [MUL_W-1:0]     prod_x, prod_y;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   gstw_pkg::gstw_rsp_type rsp_data_ff, rsp_data_in;

   logic                 x_done, y_done, move_x, move_y;
   logic [GRID_BITS-1:0] step_col, step_row;

   assign x0_wide = 32'(req_data.start_x);
   assign y0_wide = 32'(req_data.start_y);
   assign x1_wide = 32'(req_data.end_x);
   assign y1_wide = 32'(req_data.end_y);
   assign x0 = x0_wide[COORD_W-1:0];
   assign y0 = y0_wide[COORD_W-1:0];
   assign x1 = x1_wide[COORD_W-1:0];
   assign y1 = y1_wide[COORD_W-1:0];
   assign col0 = x0[COORD_W-1:FRAC_BITS];
   assign row0 = y0[COORD_W-1:FRAC_BITS];
   assign col1 = x1[COORD_W-1:FRAC_BITS];
   assign row1 = y1[COORD_W-1:FRAC_BITS];
   assign x_up   = x1 > x0;
   assign x_down = x1 < x0;
   assign y_up   = y1 > y0;
   assign y_down = y1 < y0;

   assign prod_x = dist_x_ff * ady_ff;
   assign prod_y = dist_y_ff * adx_ff;

   assign x_done = cur_col_ff == goal_col_ff;
   assign y_done = cur_row_ff == goal_row_ff;
   assign move_x = !x_done && (y_done || tx_ff <= ty_ff);
   assign move_y = !y_done && (x_done || ty_ff <= tx_ff);

   always_comb begin
      if (!move_x) begin
         step_col = cur_col_ff;
      end else if (x_down_ff) begin
         step_col = cur_col_ff - GRID_BITS'(1);
      end else begin
         step_col = cur_col_ff + GRID_BITS'(1);
      end
      if (!move_y) begin
         step_row = cur_row_ff;
      end else if (y_down_ff) begin
         step_row = cur_row_ff - GRID_BITS'(1);
      end else begin
         step_row = cur_row_ff + GRID_BITS'(1);
      end
   end

   assign status.same_tile  = (col0 == col1) && (row0 == row1);
   assign status.reach_goal = (step_col == goal_col_ff) && (step_row == goal_row_ff);

   always_comb begin
      cur_col_in    = cur_col_ff;
      cur_row_in    = cur_row_ff;
      goal_col_in   = goal_col_ff;
      goal_row_in   = goal_row_ff;
      dist_x_in     = dist_x_ff;
      dist_y_in     = dist_y_ff;
      adx_in        = adx_ff;
      ady_in        = ady_ff;
      x_down_in     = x_down_ff;
      y_down_in     = y_down_ff;
      tx_in         = tx_ff;
      ty_in         = ty_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      priority if (cmd.load) begin
         cur_col_in  = col0;
         cur_row_in  = row0;
         goal_col_in = col1;
         goal_row_in = row1;
         x_down_in   = x_down;
         y_down_in   = y_down;
         adx_in      = x_up ? (x1 - x0) : (x0 - x1);
         ady_in      = y_up ? (y1 - y0) : (y0 - y1);
         if (x_up) begin
            dist_x_in = TILE_SIZE - DIST_W'(x0[FRAC_BITS-1:0]);
         end else if (x_down) begin
            dist_x_in = DIST_W'(x0[FRAC_BITS-1:0]);
         end else begin
            dist_x_in = '0;
         end
         if (y_up) begin
            dist_y_in = TILE_SIZE - DIST_W'(y0[FRAC_BITS-1:0]);
         end else if (y_down) begin
            dist_y_in = DIST_W'(y0[FRAC_BITS-1:0]);
         end else begin
            dist_y_in = '0;
         end
         rsp_strobe_in         = 1'b1;
         rsp_data_in.tile_x    = gstw_pkg::TILE_W'(col0);
         rsp_data_in.tile_y    = gstw_pkg::TILE_W'(row0);
         rsp_data_in.last_tile = status.same_tile;
      end else if (cmd.mult) begin
         tx_in = PROD_W'(prod_x);
         ty_in = PROD_W'(prod_y);
      end else if (cmd.step) begin
         cur_col_in = step_col;
         cur_row_in = step_row;
         if (move_x) begin
            tx_in = tx_ff + (PROD_W'(ady_ff) << FRAC_BITS);
         end
         if (move_y) begin
            ty_in = ty_ff + (PROD_W'(adx_ff) << FRAC_BITS);
         end
         rsp_strobe_in         = 1'b1;
         rsp_data_in.tile_x    = gstw_pkg::TILE_W'(step_col);
         rsp_data_in.tile_y    = gstw_pkg::TILE_W'(step_row);
         rsp_data_in.last_tile = status.reach_goal;
      end else begin
         rsp_strobe_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_col_ff  <= cur_col_in;
      cur_row_ff  <= cur_row_in;
      goal_col_ff <= goal_col_in;
      goal_row_ff <= goal_row_in;
      dist_x_ff   <= dist_x_in;
      dist_y_ff   <= dist_y_in;
      adx_ff      <= adx_in;
      ady_ff      <= ady_in;
      x_down_ff   <= x_down_in;
      y_down_ff   <= y_down_in;
      tx_ff       <= tx_in;
      ty_ff       <= ty_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

   a_step_not_at_goal: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (!x_done || !y_done))
      else $error("Walk step issued while already at the goal tile.");

   a_step_moves: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (move_x || move_y))
      else $error("Walk step made no progress.");

   a_emit_follows_cmd: assert property (@(posedge clock) disable iff (reset)
      (cmd.load || cmd.step) |=> rsp_strobe_ff)
      else $error("Tile was not emitted after a load or step.");

endmodule

// ----- rtl/gstw_controller.sv -----
// Controller of the grid segment tile walk: state machine and tile counter
// that sequence load, crossing setup and walk steps.
// Depends on gstw_pkg; commands gstw_datapath.
module gstw_controller (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  gstw_pkg::gstw_status_type status,
   output gstw_pkg::gstw_cmd_type    cmd
);

   gstw_pkg::gstw_state_type state_ff, state_in;
   logic [gstw_pkg::CNT_W-1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gstw_pkg::GSTW_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      cmd      = '0;
      busy     = state_ff != gstw_pkg::GSTW_IDLE;
      unique case (state_ff)
         gstw_pkg::GSTW_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               count_in = gstw_pkg::CNT_W'(1);
               if (!status.same_tile) begin
                  state_in = gstw_pkg::GSTW_MULT;
               end
            end
         end
         gstw_pkg::GSTW_MULT: begin
            cmd.mult = 1'b1;
            state_in = gstw_pkg::GSTW_WALK;
         end
         gstw_pkg::GSTW_WALK: begin
            cmd.step = 1'b1;
            count_in = count_ff + gstw_pkg::CNT_W'(1);
            if (status.reach_goal ||
                count_ff == gstw_pkg::CNT_W'(gstw_pkg::MAX_TILES - 1)) begin
               state_in = gstw_pkg::GSTW_IDLE;
            end
         end
         default: begin
            state_in = gstw_pkg::GSTW_IDLE;
         end
      endcase
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gstw_pkg::GSTW_WALK) |->
         (count_ff < gstw_pkg::CNT_W'(gstw_pkg::MAX_TILES)))
      else $error("Tile count passed its bound.");

   a_mult_then_walk: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gstw_pkg::GSTW_MULT) |=> (state_ff == gstw_pkg::GSTW_WALK))
      else $error("Crossing setup was not followed by the walk.");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.mult, cmd.step}))
      else $error("More than one datapath command at once.");

endmodule

// ----- rtl/grid_segment_tile_walk.sv -----
// Grid segment tile walk top level: controller plus datapath, depends on gstw_pkg.
// The start tile appears on the strobe in the cycle after the transaction is accepted.
// A walk passes the crossing setup state, then gives one further tile per cycle on the strobe.
// busy is high through the setup and walk states; a single-tile item never raises it.
// A new item is taken only once the last is done and the block is idle; a walk gives at most 63 tiles.
// Synchronous reset returns the controller to idle; results cannot be stalled.
module grid_segment_tile_walk #(
   parameter int unsigned GRID_BITS = 5,
   parameter int unsigned FRAC_BITS = 11
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  gstw_pkg::gstw_req_type req_data,
   output logic                   rsp_strobe,
   output gstw_pkg::gstw_rsp_type rsp_data
);

   gstw_pkg::gstw_cmd_type    cmd;
   gstw_pkg::gstw_status_type status;

   gstw_controller u_controller (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   gstw_datapath #(
      .GRID_BITS (GRID_BITS),
      .FRAC_BITS (FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

// ----- tb/tb_grid_segment_tile_walk.sv -----
// Self-checking testbench for grid_segment_tile_walk: directed and random segments,
// a built-in tile tracer as predictor, a burst driver and a strobe monitor.
// Depends on gstw_pkg and the grid_segment_tile_walk RTL.
module tb_grid_segment_tile_walk;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 11;
   localparam logic [16:0] TILE_SPAN = 17'd1 << FRAC;

   typedef struct {
      gstw_pkg::gstw_req_type seg;
      bit                     drain;
   } segment_job_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   gstw_pkg::gstw_req_type req_data = '0;
   logic                   busy;
   logic                   rsp_strobe;
   gstw_pkg::gstw_rsp_type rsp_data;

   segment_job_type        job_q[$];
   gstw_pkg::gstw_rsp_type tile_q[$];

   int tiles_expected = 0;
   int tiles_seen = 0;
   int segments_walked = 0;
   int longest_walk = 0;
   int mismatches = 0;

   int                     burst_left;
   int                     gap_left;
   int                     walk_len;
   bit                     took;
   segment_job_type        job;
   gstw_pkg::gstw_rsp_type want;

   grid_segment_tile_walk DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int trace_tiles(gstw_pkg::gstw_req_type seg);
      logic [4:0]  col, row, goal_col, goal_row;
      logic [16:0] dist_x, dist_y;
      logic [15:0] span_x, span_y;
      logic [33:0] t_x, t_y;
      logic        x_down, y_down, at_goal, move_x, move_y;
      int          count;
      col      = seg.start_x[15:FRAC];
      row      = seg.start_y[15:FRAC];
      goal_col = seg.end_x[15:FRAC];
      goal_row = seg.end_y[15:FRAC];
      x_down   = seg.end_x < seg.start_x;
      y_down   = seg.end_y < seg.start_y;
      span_x   = x_down ? seg.start_x - seg.end_x : seg.end_x - seg.start_x;
      span_y   = y_down ? seg.start_y - seg.end_y : seg.end_y - seg.start_y;
      if (seg.end_x > seg.start_x) begin
         dist_x = (({12'b0, col} + 17'd1) << FRAC) - {1'b0, seg.start_x};
      end else if (x_down) begin
         dist_x = {6'b0, seg.start_x[FRAC-1:0]};
      end else begin
         dist_x = '0;
      end
      if (seg.end_y > seg.start_y) begin
         dist_y = (({12'b0, row} + 17'd1) << FRAC) - {1'b0, seg.start_y};
      end else if (y_down) begin
         dist_y = {6'b0, seg.start_y[FRAC-1:0]};
      end else begin
         dist_y = '0;
      end
      count = 0;
      while (1) begin
         at_goal = (col == goal_col) && (row == goal_row);
         tile_q.push_back(gstw_pkg::gstw_rsp_type'{tile_x: col, tile_y: row,
                                                   last_tile: at_goal});
         count++;
         if (at_goal || count == gstw_pkg::MAX_TILES) break;
         t_x = {17'b0, dist_x} * {18'b0, span_y};
         t_y = {17'b0, dist_y} * {18'b0, span_x};
         if (col == goal_col) begin
            move_x = 1'b0;
            move_y = 1'b1;
         end else if (row == goal_row) begin
            move_x = 1'b1;
            move_y = 1'b0;
         end else begin
            move_x = t_x <= t_y;
            move_y = t_x >= t_y;
         end
         if (move_x) begin
            col    = x_down ? col - 5'd1 : col + 5'd1;
            dist_x = dist_x + TILE_SPAN;
         end
         if (move_y) begin
            row    = y_down ? row - 5'd1 : row + 5'd1;
            dist_y = dist_y + TILE_SPAN;
         end
      end
      return count;
   endfunction

   function automatic void add_segment(int x0, int y0, int x1, int y1, bit drain);
      segment_job_type j;
      j.seg   = '{start_x: x0[15:0], start_y: y0[15:0], end_x: x1[15:0], end_y: y1[15:0]};
      j.drain = drain;
      job_q.push_back(j);
   endfunction

   function automatic int aligned_coord();
      int frac;
      case ($urandom_range(0, 3))
         0: frac = 0;
         1: frac = 'h7ff;
         2: frac = 'h400;
         default: frac = $urandom_range(0, 'h7ff);
      endcase
      return ($urandom_range(0, 31) << FRAC) | frac;
   endfunction

   function automatic int nudge(int c);
      int n;
      n = c + $urandom_range(0, 'h3000) - 'h1800;
      if (n < 0) n = 0;
      if (n > 'hffff) n = 'hffff;
      return n;
   endfunction

   task automatic check_field(string what, int expected, int actual);
      if (expected != actual) begin
         mismatches++;
         $display("%0t ns: %s expected %0d actual %0d", $time, what, expected, actual);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         burst_left = 6;
         gap_left = 0;
      end else begin
         took = start && !busy;
         if (took) begin
            walk_len = trace_tiles(req_data);
            tiles_expected <= tiles_expected + walk_len;
            segments_walked <= segments_walked + 1;
            if (walk_len > longest_walk) longest_walk <= walk_len;
         end
         if (start && !took) begin
            start <= 1'b1;
         end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left--;
         end else if (job_q.size() == 0) begin
            start <= 1'b0;
         end else if (job_q[0].drain && (took || tiles_expected != tiles_seen)) begin
            start <= 1'b0;
         end else begin
            job = job_q.pop_front();
            req_data <= job.seg;
            start <= 1'b1;
            burst_left--;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 70);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         tiles_seen <= tiles_seen + 1;
         if (tile_q.size() == 0) begin
            mismatches++;
            $display("%0t ns: tile expected none actual (%0d,%0d) last %0d", $time,
                     rsp_data.tile_x, rsp_data.tile_y, rsp_data.last_tile);
         end else begin
            want = tile_q.pop_front();
            check_field("tile_x", want.tile_x, rsp_data.tile_x);
            check_field("tile_y", want.tile_y, rsp_data.tile_y);
            check_field("last_tile", want.last_tile, rsp_data.last_tile);
         end
      end
   end

   initial begin
      int kind, x0, y0;
      add_segment('h0000, 'h0000, 'h0000, 'h0000, 0);
      add_segment('hffff, 'hffff, 'hffff, 'hffff, 0);
      add_segment('h0100, 'h0200, 'h07ff, 'h0700, 0);
      add_segment('h0000, 'h0000, 'hffff, 'hffff, 0);
      add_segment('hffff, 'h0000, 'h0000, 'hffff, 0);
      add_segment('h0000, 'h8000, 'hffff, 'h8000, 0);
      add_segment('hffff, 'h8123, 'h0000, 'h8123, 0);
      add_segment('h0400, 'hffff, 'h0400, 'h0000, 0);
      add_segment('h7abc, 'h0000, 'h7abc, 'hffff, 0);
      add_segment('h0800, 'h0800, 'h0100, 'h0100, 0);
      add_segment('h1000, 'h3000, 'h0fff, 'h2fff, 0);
      add_segment('h0000, 'h0000, 'h0800, 'h0800, 0);
      add_segment('h0800, 'h0000, 'h0000, 'h0800, 0);
      add_segment('h0000, 'h0800, 'h0800, 'h0000, 0);
      add_segment('h07ff, 'h07ff, 'h0800, 'h0800, 0);
      add_segment('h0001, 'h0000, 'hffff, 'hfffe, 1);
      add_segment('hfffe, 'hffff, 'h0000, 'h0001, 0);
      add_segment('h1234, 'hfedc, 'hedcb, 'h2345, 0);
      add_segment('haaaa, 'h5555, 'h5555, 'haaaa, 0);
      add_segment('h0400, 'h0400, 'h1c00, 'h0c00, 0);
      for (int i = 0; i < 110; i++) begin
         kind = $urandom_range(0, 9);
         if (kind < 3) begin
            add_segment($urandom_range(0, 'hffff), $urandom_range(0, 'hffff),
                        $urandom_range(0, 'hffff), $urandom_range(0, 'hffff), i % 45 == 44);
         end else if (kind < 6) begin
            x0 = $urandom_range(0, 'hffff);
            y0 = $urandom_range(0, 'hffff);
            add_segment(x0, y0, nudge(x0), nudge(y0), i % 45 == 44);
         end else if (kind < 9) begin
            add_segment(aligned_coord(), aligned_coord(), aligned_coord(), aligned_coord(),
                        i % 45 == 44);
         end else begin
            x0 = $urandom_range(0, 31) << FRAC;
            y0 = $urandom_range(0, 31) << FRAC;
            add_segment(x0 | $urandom_range(0, 'h7ff), y0 | $urandom_range(0, 'h7ff),
                        x0 | $urandom_range(0, 'h7ff), y0 | $urandom_range(0, 'h7ff),
                        i % 45 == 44);
         end
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      do @(negedge clock); while (job_q.size() != 0 || start);
      do @(negedge clock); while (tiles_seen != tiles_expected);
      repeat (80) @(negedge clock);
      if (tile_q.size() != 0) begin
         mismatches += tile_q.size();
         $display("%0t ns: %0d tiles expected but never seen", $time, tile_q.size());
      end
      $display("Walked %0d segments and checked %0d tiles; longest walk %0d tiles.",
               segments_walked, tiles_seen, longest_walk);
      if (mismatches == 0) begin
         $display("tb_grid_segment_tile_walk: done, clean");
      end else begin
         $display("tb_grid_segment_tile_walk: done, errors");
      end
      $finish;
   end

   initial begin
      #1_000_000;
      $display("Timed out with %0d tiles outstanding.", tile_q.size());
      $display("tb_grid_segment_tile_walk: done, errors");
      $finish;
   end

endmodule
